>>> rtl/core/rbc_pkg.sv
// Shared types and constants for the ROM/RAM bank controller.
// No dependencies; imported by every module of the controller.
package rbc_pkg;

    // Defaults for the top-level parameters
    localparam int RAM_BANKS_DEF     = 4;
    localparam int ROM_BANK_BITS_DEF = 7;

    // Fixed geometry
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_OFS_W      = 13;   // byte offset within one RAM bank
    localparam int ROM_OFS_W      = 14;   // byte offset within one ROM bank
    localparam int ROM_ADDR_W     = 21;

    // Decoupling queue between decode and execute
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // 8 KiB bus regions, taken from address bits 15:13
    localparam logic [2:0] REGION_RAM_EN  = 3'd0;
    localparam logic [2:0] REGION_ROM_LO  = 3'd1;
    localparam logic [2:0] REGION_ROM_HI  = 3'd2;
    localparam logic [2:0] REGION_MODE    = 3'd3;
    localparam logic [2:0] REGION_EXT_RAM = 3'd5;

    // Key value in the low nibble that enables external RAM
    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam logic [7:0] RAM_OFF_DATA = 8'hFF;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ROM   = 2'd0,
        KIND_RAM   = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // One decoded operation, passed from decode to execute
    typedef struct packed {
        kind_t                   kind;
        logic [ROM_ADDR_W-1:0]   rom_address;
        logic [1:0]              ram_bank;
        logic [RAM_OFS_W-1:0]    ram_offset;
        logic                    ram_wr;      // enabled RAM write
        logic                    ram_rd;      // enabled RAM read
        logic [7:0]              write_data;
    } op_t;

endpackage

>>> rtl/core/rbc_front.sv
// Decode stage of the bank controller: accepts bus accesses, updates the bank
// registers and builds a decoded operation. Depends on rbc_pkg.
module rbc_front
    import rbc_pkg::*;
#(
    parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic        q_full,
    output logic        q_push,
    output op_t         q_op
);

    logic [6:0] rom_bank_reg, rom_bank_next;
    logic       bank_mode_reg, bank_mode_next;
    logic       ram_en_reg, ram_en_next;

    logic [2:0] region;
    logic       accept;
    logic [4:0] low_bits;
    logic [6:0] rom_sel;

    assign region  = s_address[15:13];
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    // Bank register updates on accepted control writes
    always_comb begin
        rom_bank_next  = rom_bank_reg;
        bank_mode_next = bank_mode_reg;
        ram_en_next    = ram_en_reg;
        low_bits       = (s_write_data[4:0] == 5'd0) ? 5'd1 : s_write_data[4:0];
        if (accept && s_mode && !s_address[15]) begin
            case (region)
                REGION_RAM_EN: ram_en_next    = (s_write_data[3:0] == RAM_EN_KEY);
                REGION_ROM_LO: rom_bank_next  = {rom_bank_reg[6:5], low_bits};
                REGION_ROM_HI: rom_bank_next  = {s_write_data[1:0], rom_bank_reg[4:0]};
                REGION_MODE:   bank_mode_next = s_write_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg  <= '0;
            bank_mode_reg <= 1'b0;
            ram_en_reg    <= 1'b0;
        end else begin
            rom_bank_reg  <= rom_bank_next;
            bank_mode_reg <= bank_mode_next;
            ram_en_reg    <= ram_en_next;
        end
    end

    // Classify the access against the registers as they stand before it
    always_comb begin
        rom_sel = bank_mode_reg ? {2'b00, rom_bank_reg[4:0]} : rom_bank_reg;
        if (rom_sel == 7'd0) begin
            rom_sel = 7'd1;
        end

        q_op             = '0;
        q_op.kind        = KIND_ERROR;
        q_op.ram_bank    = bank_mode_reg ? rom_bank_reg[6:5] : 2'b00;
        q_op.ram_offset  = s_address[RAM_OFS_W-1:0];
        q_op.write_data  = s_write_data;

        if (region == REGION_EXT_RAM) begin
            q_op.kind   = s_mode ? KIND_WRITE : KIND_RAM;
            q_op.ram_wr = s_mode && ram_en_reg;
            q_op.ram_rd = !s_mode && ram_en_reg;
        end else if (!s_address[15]) begin
            if (s_mode) begin
                q_op.kind = KIND_WRITE;
            end else begin
                q_op.kind = KIND_ROM;
                if (!s_address[14]) begin
                    q_op.rom_address = ROM_ADDR_W'(s_address);
                end else begin
                    q_op.rom_address = ROM_ADDR_W'({rom_sel[ROM_BANK_BITS-1:0],
                                                    s_address[ROM_OFS_W-1:0]});
                end
            end
        end
    end

endmodule

>>> rtl/core/rbc_queue.sv
// Short FIFO of decoded operations between decode and execute.
// Depends on rbc_pkg for the operation type and depth.
module rbc_queue
    import rbc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  pop_op,
    output logic empty
);

    op_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> rtl/core/rbc_back.sv
// Execute stage of the bank controller: external RAM array and result
// register. Depends on rbc_pkg.
module rbc_back
    import rbc_pkg::*;
#(
    parameter int RAM_BANKS = RAM_BANKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  op_t                   q_op,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [ROM_ADDR_W-1:0] m_rom_address,
    output logic [7:0]            m_read_data
);

    localparam int BANK_W    = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
    localparam int IDX_W     = BANK_W + RAM_OFS_W;
    localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;

    logic [7:0] mem [RAM_DEPTH];

    logic                  out_valid_reg;
    kind_t                 kind_reg;
    logic [ROM_ADDR_W-1:0] rom_addr_reg;
    logic                  rd_mem_reg;
    logic                  rd_off_reg;
    logic [7:0]            mem_q_reg;

    logic [2:0]       bank_mod;
    logic [IDX_W-1:0] ram_idx;

    // Take the next operation when the result register is free or drains
    assign q_pop = !q_empty && (!out_valid_reg || m_ready);

    // Fold the bank number into the fitted bank count
    always_comb begin
        bank_mod = {1'b0, q_op.ram_bank};
        if (RAM_BANKS == 1) begin
            bank_mod = 3'd0;
        end else if (bank_mod >= 3'(RAM_BANKS)) begin
            bank_mod = bank_mod - 3'(RAM_BANKS);
        end
        ram_idx = IDX_W'({bank_mod, q_op.ram_offset});
    end

    // RAM access, read data registered
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (q_op.ram_wr) begin
                mem[ram_idx] <= q_op.write_data;
            end
            mem_q_reg <= mem[ram_idx];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg     <= q_op.kind;
            rom_addr_reg <= q_op.rom_address;
            rd_mem_reg   <= q_op.ram_rd;
            rd_off_reg   <= (q_op.kind == KIND_RAM) && !q_op.ram_rd;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = kind_reg;
    assign m_rom_address = rom_addr_reg;
    assign m_read_data   = rd_mem_reg ? mem_q_reg : (rd_off_reg ? RAM_OFF_DATA : 8'h00);

endmodule

>>> rtl/core/rom_ram_bank_controller_unit.sv
// ROM/RAM bank controller top level: one bus access in, one result out.
// An accepted access is stored in the queue, then registered in the result register.
// Throughput: one access per cycle while m_ready is high; the RAM sees one access per
// cycle on its single port, and a 2-entry queue decouples decode from execute.
// Reset (aresetn low, synchronous): bank registers, mode and RAM enable clear,
// queue and result register empty; RAM contents are undefined until written.
module rom_ram_bank_controller_unit
    import rbc_pkg::*;
#(
    parameter int RAM_BANKS     = RAM_BANKS_DEF,
    parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [15:0]           s_address,
    input  logic [7:0]            s_write_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [ROM_ADDR_W-1:0] m_rom_address,
    output logic [7:0]            m_read_data
);

    logic q_full, q_push, q_pop, q_empty;
    op_t  push_op, pop_op;

    rbc_front #(
        .ROM_BANK_BITS(ROM_BANK_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_op         (push_op)
    );

    rbc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (pop_op),
        .empty   (q_empty)
    );

    rbc_back #(
        .RAM_BANKS(RAM_BANKS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_op          (pop_op),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_rom_address (m_rom_address),
        .m_read_data   (m_read_data)
    );

endmodule

>>> rtl/core/rbc_checker.sv
// Port-level checks for the bank controller, bound to the top level.
// Depends on rbc_pkg and rom_ram_bank_controller_unit.
module rbc_checker
    import rbc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_kind,
    input logic [ROM_ADDR_W-1:0] m_rom_address,
    input logic [7:0]            m_read_data
);

    // Reset empties the result side
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind)
            && $stable(m_rom_address) && $stable(m_read_data))
        else $error("stalled result changed");

    // Fields that do not belong to the kind read as zero
    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_ROM && m_read_data == 8'h00)
            || (m_kind == KIND_RAM && m_rom_address == '0)
            || (m_kind == KIND_WRITE && m_rom_address == '0 && m_read_data == 8'h00)
            || (m_kind == KIND_ERROR && m_rom_address == '0 && m_read_data == 8'h00))
        else $error("unused result field not zero");

    // An input transfer into an empty result side shows a result after the queue and the result register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> ##1 m_valid)
        else $error("result did not appear in time");

endmodule

bind rom_ram_bank_controller_unit rbc_checker u_rbc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_rom_address (m_rom_address),
    .m_read_data   (m_read_data)
);
